// File: rtl/ccb_pkg.sv
`default_nettype none

package ccb_pkg;

	// Pipeline depth of one blend lane (and of the whole block)
	localparam int unsigned Stages = 7;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_PIXEL_FORMAT = 3'd0,
		REG_FULL_GRAY    = 3'd1,
		REG_PEN_PACKED16 = 3'd2,
		REG_PEN_BYTE0    = 3'd3,
		REG_PEN_BYTE1    = 3'd4,
		REG_PEN_BYTE2    = 3'd5,
		REG_PEN_BYTE3    = 3'd6,
		REG_UNUSED       = 3'd7
	} reg_index_t;

	// Destination pixel formats
	typedef enum logic [1:0] {
		FMT_RGB555 = 2'd0,
		FMT_RGB565 = 2'd1,
		FMT_BYTE3  = 2'd2,
		FMT_BYTE4  = 2'd3
	} pix_fmt_t;

	// Channel masks
	localparam logic [7:0] Ch5Mask = 8'h1F;
	localparam logic [7:0] Ch6Mask = 8'h3F;

	// Four restoring division steps: returns {remainder, quotient bits}
	function automatic logic [11:0] div_step4(input logic [7:0] rem_in,
			input logic [3:0] bits_in, input logic [7:0] dvs);
		logic [8:0] r9;
		logic [7:0] r;
		logic [3:0] q;
		r = rem_in;
		q = 4'd0;
		for (int i = 3; i >= 0; i--) begin
			r9 = {r, bits_in[i]};
			if (r9 >= {1'b0, dvs}) begin
				r9 = r9 - {1'b0, dvs};
				q[i] = 1'b1;
			end
			r = r9[7:0];
		end
		return {r, q};
	endfunction

endpackage

`default_nettype wire

// File: rtl/ccb_lane.sv
`default_nettype none

// One color channel: multiply, magnitude, 16-bit divide in four
// radix-16 stages, then signed step applied to the channel.
module ccb_lane import ccb_pkg::*; (
	input  wire logic              clk,
	input  wire logic [Stages-1:0] en,
	input  wire logic [7:0]        cov,
	input  wire logic [7:0]        chan_in,
	input  wire logic [7:0]        pen_in,
	input  wire logic [7:0]        mx,
	output logic [7:0]             chan_out
);

	logic signed [8:0]  diff;
	logic signed [17:0] prod;
	logic signed [17:0] num;
	logic signed [17:0] num_s1;
	logic [7:0]         c_s1;
	logic [17:0]        mag;
	logic [15:0]        v_s2;
	logic               neg_s2;
	logic [7:0]         c_s2;

	logic [7:0]  rem_s [4];
	logic [15:0] quo_s [4];
	logic [15:0] val_s [4];
	logic        neg_s [4];
	logic [7:0]  chn_s [4];
	logic [11:0] step  [4];

	logic [8:0] q9;
	logic [8:0] sum;

	// Stage 1: coverage * (pen - chan) + max/2
	assign diff = $signed({1'b0, pen_in}) - $signed({1'b0, chan_in});
	assign prod = $signed({1'b0, cov}) * diff;
	assign num  = prod + $signed({11'd0, mx[7:1]});

	always_ff @(posedge clk) begin
		if (en[0]) begin
			num_s1 <= num;
			c_s1   <= chan_in;
		end
	end

	// Stage 2: sign and magnitude
	assign mag = num_s1[17] ? 18'(-num_s1) : 18'(num_s1);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			v_s2   <= mag[15:0];
			neg_s2 <= num_s1[17];
			c_s2   <= c_s1;
		end
	end

	// Stages 3..6: four quotient bits per stage, MSB first
	assign step[0] = div_step4(8'd0, v_s2[15:12], mx);
	for (genvar j = 1; j < 4; j++) begin : g_step
		assign step[j] = div_step4(rem_s[j-1], val_s[j-1][15-4*j -: 4], mx);
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			rem_s[0] <= step[0][11:4];
			quo_s[0] <= {12'd0, step[0][3:0]};
			val_s[0] <= v_s2;
			neg_s[0] <= neg_s2;
			chn_s[0] <= c_s2;
		end
		for (int k = 1; k < 4; k++) begin
			if (en[k+2]) begin
				rem_s[k] <= step[k][11:4];
				quo_s[k] <= {quo_s[k-1][11:0], step[k][3:0]};
				val_s[k] <= val_s[k-1];
				neg_s[k] <= neg_s[k-1];
				chn_s[k] <= chn_s[k-1];
			end
		end
	end

	// Stage 7: truncated quotient fits 8 bits; apply sign and add
	assign q9  = neg_s[3] ? 9'(-{1'b0, quo_s[3][7:0]}) : {1'b0, quo_s[3][7:0]};
	assign sum = {1'b0, chn_s[3]} + q9;

	always_ff @(posedge clk) begin
		if (en[6]) begin
			chan_out <= sum[7:0];
		end
	end

endmodule

`default_nettype wire

// File: rtl/coverage_color_blend.sv
// Pipeline: seven register stages; out_valid rises when a pixel reaches the last stage.
// Throughput: one pixel per cycle unless the receiver stalls; each pipeline stage loads
// when it is empty or its successor moves, so a stall holds data in place.
// The divide by the full-coverage gray level takes four of those stages, four bits each.
// Reset: arst_n clears all valid bits and loads the register reset values.
`default_nettype none

module coverage_color_blend import ccb_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  coverage,
	input  wire logic [31:0] dest_pixel,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      new_pixel,
	output logic             write_enable
);

	pix_fmt_t    fmt_q;
	logic [7:0]  full_gray_q;
	logic [15:0] pen16_q;
	logic [7:0]  pen0_q, pen1_q, pen2_q, pen3_q;

	logic [Stages-1:0] en;
	logic              vld_s  [Stages];
	logic              zero_s [Stages];
	logic              full_s [Stages];
	logic [31:0]       dest_s [Stages];

	logic [7:0] mx;
	logic [7:0] c0, c1, c2, p0, p1, p2;
	logic [7:0] r0, r1, r2;
	logic [31:0] part_pix, full_pix;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q       <= FMT_RGB565;
			full_gray_q <= 8'd255;
			pen16_q     <= 16'd0;
			pen0_q      <= 8'd0;
			pen1_q      <= 8'd0;
			pen2_q      <= 8'd0;
			pen3_q      <= 8'd0;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_PIXEL_FORMAT: fmt_q       <= pix_fmt_t'(cfg_data[1:0]);
				REG_FULL_GRAY:    full_gray_q <= cfg_data[7:0];
				REG_PEN_PACKED16: pen16_q     <= cfg_data;
				REG_PEN_BYTE0:    pen0_q      <= cfg_data[7:0];
				REG_PEN_BYTE1:    pen1_q      <= cfg_data[7:0];
				REG_PEN_BYTE2:    pen2_q      <= cfg_data[7:0];
				REG_PEN_BYTE3:    pen3_q      <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign mx = (full_gray_q == 8'd0) ? 8'd1 : full_gray_q;

	// Stage enables: a stage moves when empty or when its successor moves
	assign en[Stages-1] = !vld_s[Stages-1] || out_ready;
	for (genvar k = 0; k < Stages-1; k++) begin : g_en
		assign en[k] = !vld_s[k] || en[k+1];
	end
	assign in_ready = en[0];

	// Channel extraction per format (lane 0 = blue / byte 0)
	always_comb begin
		unique case (fmt_q)
			FMT_RGB555: begin
				c0 = {3'd0, dest_pixel[4:0]};
				c1 = {3'd0, dest_pixel[9:5]};
				c2 = {3'd0, dest_pixel[14:10]};
				p0 = {3'd0, pen16_q[4:0]};
				p1 = {3'd0, pen16_q[9:5]};
				p2 = {3'd0, pen16_q[14:10]};
			end
			FMT_RGB565: begin
				c0 = {3'd0, dest_pixel[4:0]};
				c1 = {2'd0, dest_pixel[10:5]};
				c2 = {3'd0, dest_pixel[15:11]};
				p0 = {3'd0, pen16_q[4:0]};
				p1 = {2'd0, pen16_q[10:5]};
				p2 = {3'd0, pen16_q[15:11]};
			end
			default: begin
				c0 = dest_pixel[7:0];
				c1 = dest_pixel[15:8];
				c2 = dest_pixel[23:16];
				p0 = pen0_q;
				p1 = pen1_q;
				p2 = pen2_q;
			end
		endcase
	end

	// Sideband pipeline: valid, coverage class, original pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < Stages; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else begin
			if (en[0]) begin
				vld_s[0] <= in_valid;
			end
			for (int k = 1; k < Stages; k++) begin
				if (en[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			zero_s[0] <= (coverage == 8'd0);
			full_s[0] <= (coverage >= mx);
			dest_s[0] <= dest_pixel;
		end
		for (int k = 1; k < Stages; k++) begin
			if (en[k]) begin
				zero_s[k] <= zero_s[k-1];
				full_s[k] <= full_s[k-1];
				dest_s[k] <= dest_s[k-1];
			end
		end
	end

	// Three blend lanes
	ccb_lane u_lane0 (.clk, .en, .cov(coverage), .chan_in(c0), .pen_in(p0), .mx,
		.chan_out(r0));
	ccb_lane u_lane1 (.clk, .en, .cov(coverage), .chan_in(c1), .pen_in(p1), .mx,
		.chan_out(r1));
	ccb_lane u_lane2 (.clk, .en, .cov(coverage), .chan_in(c2), .pen_in(p2), .mx,
		.chan_out(r2));

	// Output packing
	always_comb begin
		unique case (fmt_q)
			FMT_RGB555: begin
				part_pix = {17'd0, r2[4:0], r1[4:0], r0[4:0]};
				full_pix = {16'd0, pen16_q};
			end
			FMT_RGB565: begin
				part_pix = {16'd0, r2[4:0], r1[5:0], r0[4:0]};
				full_pix = {16'd0, pen16_q};
			end
			FMT_BYTE3: begin
				part_pix = {8'd0, r2, r1, r0};
				full_pix = {8'd0, pen2_q, pen1_q, pen0_q};
			end
			default: begin
				part_pix = {dest_s[Stages-1][31:24], r2, r1, r0};
				full_pix = {pen3_q, pen2_q, pen1_q, pen0_q};
			end
		endcase
	end

	assign out_valid    = vld_s[Stages-1];
	assign write_enable = !zero_s[Stages-1];
	assign new_pixel    = zero_s[Stages-1] ? dest_s[Stages-1] :
		(full_s[Stages-1] ? full_pix : part_pix);

endmodule

`default_nettype wire

// File: sim/ccb_checker.sv
`timescale 1ns / 100ps
`default_nettype none

module ccb_checker import ccb_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [7:0]  coverage,
	input  wire logic [31:0] dest_pixel,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [31:0] new_pixel,
	input  wire logic        write_enable,
	output int               fail_count,
	output int               pending
);

	typedef struct packed {
		logic [31:0] pixel;
		logic        we;
	} blend_result_t;

	// Shadow copy of the block's registers
	pix_fmt_t    fmt;
	logic [7:0]  full_gray;
	logic [15:0] pen16;
	logic [7:0]  pen_b [4];

	blend_result_t blend_queue[$];

	// One channel step toward the pen, division truncating toward zero
	function automatic logic [7:0] mix(input int c, input int p, input int n, input int mx);
		int d;
		int num;
		int q;
		d   = p - c;
		num = n * d + (mx >> 1);
		q   = (num < 0) ? -((-num) / mx) : num / mx;
		return 8'(c + q);
	endfunction

	function automatic blend_result_t blend_pixel(input logic [7:0] n, input logic [31:0] dst);
		blend_result_t r;
		int mx;
		mx = (full_gray == 8'd0) ? 1 : int'(full_gray);
		r.we = (n != 8'd0);
		r.pixel = dst;
		if (n == 8'd0)
			return r;
		if (int'(n) >= mx) begin
			case (fmt)
				FMT_RGB555, FMT_RGB565: r.pixel = {16'd0, pen16};
				FMT_BYTE3: r.pixel = {8'd0, pen_b[2], pen_b[1], pen_b[0]};
				default:   r.pixel = {pen_b[3], pen_b[2], pen_b[1], pen_b[0]};
			endcase
		end else begin
			case (fmt)
				FMT_RGB555: r.pixel = {17'd0,
						5'(mix(dst[14:10], pen16[14:10], n, mx)),
						5'(mix(dst[9:5], pen16[9:5], n, mx)),
						5'(mix(dst[4:0], pen16[4:0], n, mx))};
				FMT_RGB565: r.pixel = {16'd0,
						5'(mix(dst[15:11], pen16[15:11], n, mx)),
						6'(mix(dst[10:5], pen16[10:5], n, mx)),
						5'(mix(dst[4:0], pen16[4:0], n, mx))};
				default: r.pixel = {(fmt == FMT_BYTE4) ? dst[31:24] : 8'd0,
						mix(dst[23:16], pen_b[2], n, mx),
						mix(dst[15:8], pen_b[1], n, mx),
						mix(dst[7:0], pen_b[0], n, mx)};
			endcase
		end
		return r;
	endfunction

	assign pending = blend_queue.size();

	// Track register writes, predict on request accept, compare on result accept
	always @(posedge clk or negedge arst_n) begin
		blend_result_t exp_r;
		if (!arst_n) begin
			fmt        <= FMT_RGB565;
			full_gray  <= 8'd255;
			pen16      <= 16'd0;
			pen_b      <= '{8'd0, 8'd0, 8'd0, 8'd0};
			fail_count <= 0;
			blend_queue.delete();
		end else begin
			if (cfg_we) begin
				case (reg_index_t'(cfg_index))
					REG_PIXEL_FORMAT: fmt       <= pix_fmt_t'(cfg_data[1:0]);
					REG_FULL_GRAY:    full_gray <= cfg_data[7:0];
					REG_PEN_PACKED16: pen16     <= cfg_data;
					REG_PEN_BYTE0:    pen_b[0]  <= cfg_data[7:0];
					REG_PEN_BYTE1:    pen_b[1]  <= cfg_data[7:0];
					REG_PEN_BYTE2:    pen_b[2]  <= cfg_data[7:0];
					REG_PEN_BYTE3:    pen_b[3]  <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				blend_queue.push_back(blend_pixel(coverage, dest_pixel));
			if (out_valid && out_ready) begin
				if (blend_queue.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result: pixel %h we %b", new_pixel, write_enable);
					fail_count <= fail_count + 1;
				end else begin
					exp_r = blend_queue.pop_front();
					if (exp_r.pixel !== new_pixel || exp_r.we !== write_enable) begin
						if (fail_count < 10)
							$display("mismatch: pixel exp %h got %h, we exp %b got %b",
									exp_r.pixel, new_pixel, exp_r.we, write_enable);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 100ps
`default_nettype none

module tb;
	import ccb_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  coverage;
	logic [31:0] dest_pixel;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] new_pixel;
	logic        write_enable;
	int          fail_count;
	int          pending;
	logic [7:0]  cur_gray;

	coverage_color_blend DUT (.*);

	ccb_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Receiver stall pattern: phases of free flow and of random stalls
	initial begin
		int mode;
		out_ready = 1'b0;
		forever begin
			mode = $urandom_range(0, 2);
			repeat ($urandom_range(5, 60)) begin
				@(posedge clk);
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 3) != 0);
					default: out_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	initial begin
		#20ms;
		$display("** coverage_color_blend: FAILED **");
		$finish;
	end

	task automatic write_reg(input reg_index_t idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		if (idx == REG_FULL_GRAY)
			cur_gray = val[7:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Wait until every predicted pixel is back, then let the pipe drain
	task automatic drain();
		while (pending != 0)
			@(posedge clk);
		repeat (Stages + 4) @(posedge clk);
	endtask

	// Send one request; valid stays high across back-to-back requests
	task automatic send_pixel(input logic [7:0] cov, input logic [31:0] dst);
		in_valid   <= 1'b1;
		coverage   <= cov;
		dest_pixel <= dst;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic idle_gap();
		in_valid <= 1'b0;
		repeat ($urandom_range(1, 8)) @(posedge clk);
	endtask

	task automatic set_pens(input logic [1:0] fmt, input logic [7:0] gray);
		write_reg(REG_PIXEL_FORMAT, {14'd0, fmt});
		write_reg(REG_FULL_GRAY, {8'd0, gray});
		write_reg(REG_PEN_PACKED16, 16'($urandom));
		write_reg(REG_PEN_BYTE0, 16'($urandom_range(0, 255)));
		write_reg(REG_PEN_BYTE1, 16'($urandom_range(0, 255)));
		write_reg(REG_PEN_BYTE2, 16'($urandom_range(0, 255)));
		write_reg(REG_PEN_BYTE3, 16'($urandom_range(0, 255)));
	endtask

	function automatic logic [7:0] pick_cov();
		int sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0: return 8'd0;
			1: return cur_gray;
			2: return 8'($urandom_range(cur_gray, 255));
			3: return 8'd1;
			default: return (cur_gray > 1) ? 8'($urandom_range(1, cur_gray - 1))
					: 8'($urandom);
		endcase
	endfunction

	initial begin
		int burst;
		cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
		in_valid = 1'b0; coverage = '0; dest_pixel = '0;
		cur_gray = 8'd255;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset settings, then field extremes per format
		send_pixel(8'd0, 32'hFFFF_FFFF);
		send_pixel(8'd255, 32'h1234_5678);
		send_pixel(8'd128, 32'hFFFF_FFFF);
		idle_gap();
		drain();
		for (int f = 0; f < 4; f++) begin
			write_reg(REG_PIXEL_FORMAT, 16'(f));
			write_reg(REG_FULL_GRAY, 16'd200);
			write_reg(REG_PEN_PACKED16, 16'hFFFF);
			write_reg(REG_PEN_BYTE0, 16'hFF);
			write_reg(REG_PEN_BYTE1, 16'h00);
			write_reg(REG_PEN_BYTE2, 16'hFF);
			write_reg(REG_PEN_BYTE3, 16'hA5);
			send_pixel(8'd0, 32'hDEAD_BEEF);
			send_pixel(8'd200, 32'h0000_0000);
			send_pixel(8'd255, 32'hFFFF_FFFF);
			send_pixel(8'd1, 32'h0000_0000);
			send_pixel(8'd199, 32'hFFFF_FFFF);
			idle_gap();
			drain();
		end
		// full gray level of zero: every nonzero coverage is full
		write_reg(REG_FULL_GRAY, 16'd0);
		send_pixel(8'd1, 32'h5555_AAAA);
		send_pixel(8'd0, 32'h5555_AAAA);
		idle_gap();
		drain();

		// Random phases over formats and divisors, extremes included
		for (int ph = 0; ph < 24; ph++) begin
			set_pens(2'(ph % 4), (ph < 4) ? 8'd1 : (ph < 8) ? 8'd255
					: 8'($urandom_range(0, 255)));
			repeat (50) begin
				send_pixel(pick_cov(), $urandom);
				if (burst <= 0) begin
					burst = $urandom_range(1, 20);
					if ($urandom_range(0, 1))
						idle_gap();
				end
				burst--;
			end
			idle_gap();
			drain();
		end

		in_valid <= 1'b0;
		drain();
		if (fail_count == 0)
			$display("** coverage_color_blend: PASSED **");
		else
			$display("** coverage_color_blend: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire
